### sv/scd_pkg.sv
// Shared types, register codes and the curve table generator for the soft-clip distortion.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  // Configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] CFG_ENABLE      = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_DRIVE_GAIN  = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_WET_MIX     = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] CFG_OUTPUT_GAIN = 2'd3;

  // Register values after reset
  localparam logic        RST_ENABLE      = 1'b1;
  localparam logic [15:0] RST_DRIVE_GAIN  = 16'd4096;
  localparam logic [15:0] RST_WET_MIX     = 16'd32768;
  localparam logic [15:0] RST_OUTPUT_GAIN = 16'd4096;

  // Unity in Q0.15 mix units
  localparam logic [15:0] WET_FULL = 16'd32768;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          channel_in;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          channel_out;
    logic                          last_out;
  } out_item_t;

  // One shaping job: a sample, its successor, its channel and last flag
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          ch;
    logic                          last;
  } job_t;

  typedef struct packed {
    logic        enable;
    logic [15:0] drive_gain;
    logic [15:0] wet_mix;
    logic [15:0] output_gain;
  } cfg_t;

  // Table point k of 1-exp(-t) in Q0.15, t = k * 16 / 2^table_bits.
  // exp(-t) = exp(-1)^n * exp(-f), exp(-f) from a 25-term series in Q.30.
  function automatic logic [15:0] curve_point(input int unsigned k,
                                              input int unsigned table_bits);
    logic [63:0] t;
    logic [63:0] f;
    logic [63:0] term;
    logic [63:0] e;
    longint      sum;
    int unsigned n;
    t    = 64'(k) << (19 - table_bits);
    n    = 32'(t >> 15);
    f    = (t & 64'h7fff) << 15;
    sum  = longint'(64'd1 << 30);
    term = 64'd1 << 30;
    for (int unsigned kk = 1; kk <= 24; kk++) begin
      term = ((term * f) >> 30) / 64'(kk);
      if (kk[0]) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    e = (sum < 0) ? 64'd0 : 64'(sum);
    for (int unsigned i = 0; i < n; i++) begin
      e = (e * 64'd395007542 + (64'd1 << 29)) >> 30;
    end
    return 16'(64'd32768 - ((e + 64'd16384) >> 15));
  endfunction

endpackage

### sv/scd_fifo.sv
// Small register FIFO used for the job queue and the result queue.
`timescale 1ns / 1ps

module scd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             push_ok, pop_ok;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign push_ok = push & ~full;
  assign pop_ok  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push_ok && !pop_ok) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop_ok && !push_ok) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

### sv/scd_front.sv
// Front end: accepts samples, tracks the held sample per channel and issues shaping jobs.
`timescale 1ns / 1ps

module scd_front
  import scd_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t in_data,
  output logic     full,
  output logic     job_push,
  output job_t     job_data,
  input  logic     job_full
);

  localparam int   CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic CH1_OK = (CHANNELS > 1);

  logic signed [SAMPLE_BITS-1:0] held_sample_r [CHANNELS];
  logic                          held_valid_r  [CHANNELS];
  logic                          pend_valid_r, pend_valid_nxt;
  job_t                          pend_job_r, pend_job_nxt;

  logic      accept, ch_ok, take;
  logic      hv;
  logic [CH_W-1:0] idx;
  job_t      job_a, job_b;

  assign full   = pend_valid_r | job_full;
  assign accept = push & ~full;
  assign ch_ok  = ~in_data.channel_in | CH1_OK;
  assign take   = accept & ch_ok;
  assign idx    = CH_W'(in_data.channel_in);
  assign hv     = held_valid_r[idx];

  // Held sample shaped with the new one as its successor
  always_comb begin
    job_a.x    = held_sample_r[idx];
    job_a.y    = in_data.sample_in;
    job_a.ch   = in_data.channel_in;
    job_a.last = ~in_data.block_end;
    job_b.x    = in_data.sample_in;
    job_b.y    = in_data.sample_in;
    job_b.ch   = in_data.channel_in;
    job_b.last = 1'b1;
  end

  always_comb begin
    job_push       = 1'b0;
    job_data       = pend_job_r;
    pend_valid_nxt = pend_valid_r;
    pend_job_nxt   = pend_job_r;
    if (pend_valid_r) begin
      job_push       = ~job_full;
      pend_valid_nxt = job_full;
    end else if (take && (hv || in_data.block_end)) begin
      job_push = 1'b1;
      job_data = hv ? job_a : job_b;
      if (hv && in_data.block_end) begin
        pend_valid_nxt = 1'b1;
        pend_job_nxt   = job_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
    pend_job_r <= pend_job_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        held_valid_r[c] <= 1'b0;
      end
    end else if (take) begin
      held_valid_r[idx] <= ~in_data.block_end;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_sample_r[idx] <= in_data.sample_in;
    end
  end

endmodule

### sv/scd_back.sv
// Back end: sequencer around one shared 17x17 multiplier that shapes, mixes and scales a job.
`timescale 1ns / 1ps

module scd_back
  import scd_pkg::*;
#(
  parameter int CURVE_TABLE_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_empty,
  input  job_t      job_data,
  output logic      job_pop,
  output logic      res_push,
  output out_item_t res_data,
  input  logic      res_full
);

  localparam int MAG_BITS  = 19;
  localparam int SEG_SHIFT = MAG_BITS - CURVE_TABLE_BITS;
  localparam int TABLE_LEN = (1 << CURVE_TABLE_BITS) + 1;
  localparam int TAB_AW    = CURVE_TABLE_BITS + 1;

  localparam logic signed [47:0] ROUND_HALF = 48'sd67108864;
  localparam logic signed [20:0] SAT_HI     = 21'sd32767;
  localparam logic signed [20:0] SAT_LO     = -21'sd32768;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_D1   = 4'd1;
  localparam logic [3:0] S_D2   = 4'd2;
  localparam logic [3:0] S_CLO  = 4'd3;
  localparam logic [3:0] S_CHI  = 4'd4;
  localparam logic [3:0] S_CMUL = 4'd5;
  localparam logic [3:0] S_MA   = 4'd6;
  localparam logic [3:0] S_MB   = 4'd7;
  localparam logic [3:0] S_OL   = 4'd8;
  localparam logic [3:0] S_OH   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  function automatic logic [MAG_BITS-1:0] mag_clamp(input logic signed [20:0] v);
    logic [20:0] a;
    a = v[20] ? 21'(-v) : 21'(v);
    return (a[20:MAG_BITS] != '0) ? '1 : a[MAG_BITS-1:0];
  endfunction

  logic [15:0] curve_tab [TABLE_LEN];

  for (genvar k = 0; k < TABLE_LEN; k++) begin : g_tab
    assign curve_tab[k] = curve_point(k, CURVE_TABLE_BITS);
  end

  logic [3:0]                    state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, y_r;
  logic                          ch_r, last_r, bypass_r, second_r;
  logic signed [20:0]            d1_r, d2_r, mid_r;
  logic [MAG_BITS-1:0]           cmag_r;
  logic                          csign_r;
  logic [15:0]                   lo_r;
  logic signed [16:0]            diff_r, c1_r, c2_r, w_r;
  logic signed [31:0]            pa_r, sum_r;
  logic [31:0]                   pl_r;
  logic signed [47:0]            acc_r;

  logic signed [16:0]            mul_a, mul_b;
  logic signed [33:0]            mul_p;
  logic [CURVE_TABLE_BITS-1:0]   idx;
  logic [SEG_SHIFT-1:0]          fr;
  logic [TAB_AW-1:0]             tab_addr;
  logic [15:0]                   tab_q;
  logic signed [21:0]            mid_sum;
  logic signed [17:0]            w_sum;
  logic signed [33:0]            interp;
  logic [16:0]                   cmag_val;
  logic signed [16:0]            cval;
  logic [15:0]                   wm_c, dry;
  logic signed [47:0]            rnd;
  logic signed [20:0]            r;
  logic signed [SAMPLE_BITS-1:0] sat;

  assign wm_c = (cfg.wet_mix > WET_FULL) ? WET_FULL : cfg.wet_mix;
  assign dry  = WET_FULL - wm_c;

  // Operand select for the shared multiplier
  always_comb begin
    case (state_r)
      S_D1: begin
        mul_a = {x_r[15], x_r};
        mul_b = {1'b0, cfg.drive_gain};
      end
      S_D2: begin
        mul_a = {y_r[15], y_r};
        mul_b = {1'b0, cfg.drive_gain};
      end
      S_CMUL: begin
        mul_a = diff_r;
        mul_b = 17'(fr);
      end
      S_MA: begin
        mul_a = {x_r[15], x_r};
        mul_b = {1'b0, dry};
      end
      S_MB: begin
        mul_a = w_r;
        mul_b = {1'b0, wm_c};
      end
      S_OL: begin
        mul_a = {1'b0, sum_r[15:0]};
        mul_b = {1'b0, cfg.output_gain};
      end
      S_OH: begin
        mul_a = {sum_r[31], sum_r[31:16]};
        mul_b = {1'b0, cfg.output_gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Curve table lookup: low point, then high point on the next cycle
  assign idx      = cmag_r[MAG_BITS-1:SEG_SHIFT];
  assign fr       = cmag_r[SEG_SHIFT-1:0];
  assign tab_addr = (state_r == S_CHI) ? {1'b0, idx} + TAB_AW'(1) : {1'b0, idx};
  assign tab_q    = curve_tab[tab_addr];

  assign mid_sum  = {d1_r[20], d1_r} + {d2_r[20], d2_r};
  assign interp   = mul_p >>> SEG_SHIFT;
  assign cmag_val = {1'b0, lo_r} + interp[16:0];
  assign cval     = csign_r ? -signed'(cmag_val) : signed'(cmag_val);
  assign w_sum    = {c1_r[16], c1_r} + {c2_r[16], c2_r};

  // Round half up, then saturate to the sample range
  assign rnd = acc_r + ROUND_HALF;
  assign r   = rnd[47:27];
  always_comb begin
    if (r > SAT_HI) begin
      sat = 16'sh7fff;
    end else if (r < SAT_LO) begin
      sat = 16'sh8000;
    end else begin
      sat = r[15:0];
    end
  end

  assign job_pop  = (state_r == S_IDLE) & ~job_empty;
  assign res_push = (state_r == S_OUT);

  always_comb begin
    res_data.sample_out  = bypass_r ? x_r : sat;
    res_data.channel_out = ch_r;
    res_data.last_out    = last_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!job_empty) begin
          state_nxt = cfg.enable ? S_D1 : S_OUT;
        end
      end
      S_D1:   state_nxt = S_D2;
      S_D2:   state_nxt = S_CLO;
      S_CLO:  state_nxt = S_CHI;
      S_CHI:  state_nxt = S_CMUL;
      S_CMUL: state_nxt = second_r ? S_MA : S_CLO;
      S_MA:   state_nxt = S_MB;
      S_MB:   state_nxt = S_OL;
      S_OL:   state_nxt = S_OH;
      S_OH:   state_nxt = S_OUT;
      S_OUT: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        x_r      <= job_data.x;
        y_r      <= job_data.y;
        ch_r     <= job_data.ch;
        last_r   <= job_data.last;
        bypass_r <= ~cfg.enable;
      end
      S_D1: begin
        d1_r <= mul_p[32:12];
      end
      S_D2: begin
        d2_r     <= mul_p[32:12];
        cmag_r   <= mag_clamp(d1_r);
        csign_r  <= d1_r[20];
        second_r <= 1'b0;
      end
      S_CLO: begin
        lo_r  <= tab_q;
        mid_r <= mid_sum[21:1];
      end
      S_CHI: begin
        diff_r <= signed'({1'b0, tab_q}) - signed'({1'b0, lo_r});
      end
      S_CMUL: begin
        if (!second_r) begin
          c1_r     <= cval;
          cmag_r   <= mag_clamp(mid_r);
          csign_r  <= mid_r[20];
          second_r <= 1'b1;
        end else begin
          c2_r <= cval;
        end
      end
      S_MA: begin
        pa_r <= mul_p[31:0];
        w_r  <= w_sum[17:1];
      end
      S_MB: begin
        sum_r <= pa_r + mul_p[31:0];
      end
      S_OL: begin
        pl_r <= mul_p[31:0];
      end
      S_OH: begin
        acc_r <= (48'(mul_p) <<< 16) + signed'({16'b0, pl_r});
      end
      default: begin
      end
    endcase
  end

endmodule

### sv/soft_clip_distortion_2x.sv
// Top level of the two-channel exponential soft-clipping distortion.
`timescale 1ns / 1ps

// Usage
//  Input queue: drive in_data with push high; the item is taken at a rising
//  edge with push high and full low. Each item is one sample of a channel;
//  a channel number at or above CHANNELS is dropped without effect.
//  Result queue: while empty is low the oldest result sits on out_data; pop
//  high at a rising edge takes it. Results keep their order.
//  Config port: cfg_we high writes cfg_wdata to register cfg_addr at the edge
//  (enable, drive_gain, wet_mix, output_gain); write only while idle.
//  A sample is held until the next sample of its channel arrives (one-sample
//  lookahead); an item with block_end flushes it and itself, so an item gives
//  zero, one or two results, and last_out marks the final one.
//  Flow: the front writes a job into the two-entry job queue at the transfer
//  edge (a block end's second job once the queue has room); the sequencer
//  takes one job at a time through its single 17x17 multiplier and curve
//  table port, or passes the sample straight through in bypass. A second
//  result of an item follows once the first has been through the sequencer.
//  Reset (synchronous, rst_n low) empties both queues, forgets held samples
//  and loads the default register values. When the receiver stalls, the
//  two-entry result queue fills, the sequencer holds, then the job queue
//  fills and full rises; no result is dropped.
module soft_clip_distortion_2x
  import scd_pkg::*;
#(
  parameter int CHANNELS         = 2,
  parameter int CURVE_TABLE_BITS = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  in_item_t                 in_data,
  output logic                     full,
  input  logic                     pop,
  output out_item_t                out_data,
  output logic                     empty,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int JOB_W = $bits(job_t);
  localparam int RES_W = $bits(out_item_t);

  cfg_t      cfg_r;
  logic      job_push, job_full, job_pop, job_empty;
  job_t      job_in, job_out;
  logic      res_push, res_full;
  out_item_t res_in;

  // Register file: hold the defaults from reset, update on each write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable      <= RST_ENABLE;
      cfg_r.drive_gain  <= RST_DRIVE_GAIN;
      cfg_r.wet_mix     <= RST_WET_MIX;
      cfg_r.output_gain <= RST_OUTPUT_GAIN;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLE:      cfg_r.enable      <= cfg_wdata[0];
        CFG_DRIVE_GAIN:  cfg_r.drive_gain  <= cfg_wdata;
        CFG_WET_MIX:     cfg_r.wet_mix     <= cfg_wdata;
        CFG_OUTPUT_GAIN: cfg_r.output_gain <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Front: accept samples and turn them into shaping jobs
  scd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .job_push (job_push),
    .job_data (job_in),
    .job_full (job_full)
  );

  // Job queue decouples the front from the sequencer
  scd_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (2)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // Back: drive, curve, mix and output gain on one shared multiplier
  scd_back #(
    .CURVE_TABLE_BITS (CURVE_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .job_empty (job_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res_data  (res_in),
    .res_full  (res_full)
  );

  // Result queue lets the sequencer finish while the receiver stalls
  scd_fifo #(
    .WIDTH (RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty)
  );

endmodule
